FILE: rtl/olte_pkg.sv
package olte_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int FOUND_W   = 7;
    localparam int GRP       = 8;
    localparam int NGRP      = CAPACITY / GRP;
    localparam int GRP_W     = $clog2(GRP);
    localparam int GIDX_W    = IDX_W - GRP_W;

    localparam logic [FOUND_W-1:0] NONE_IDX = {FOUND_W{1'b1}};

    typedef enum logic [3:0] {
        F_APPEND = 4'd0,
        F_INSERT = 4'd1,
        F_GET    = 4'd2,
        F_SET    = 4'd3,
        F_REMOVE = 4'd4,
        F_RMVAL  = 4'd5,
        F_SEARCH = 4'd6,
        F_CLEAR  = 4'd7,
        F_LENGTH = 4'd8
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        C_HOLD,
        C_WRITE,
        C_INSERT,
        C_REMOVE,
        C_CLEAR
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_FIND,
        S_EXEC
    } state_t;

    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      pos;
        logic [CNT_W-1:0]      cnt;
        logic [WORD_BITS-1:0]  wdata;
        logic [WORD_BITS-1:0]  key;
    } cell_ctl_t;

endpackage

FILE: rtl/olte_cell.sv
module olte_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [olte_pkg::IDX_W-1:0]          idx,
    input  olte_pkg::cell_ctl_t                 ctl,
    input  logic [olte_pkg::WORD_BITS-1:0]      left_word,
    input  logic [olte_pkg::WORD_BITS-1:0]      right_word,
    output logic [olte_pkg::WORD_BITS-1:0]      entry,
    output logic                                match,
    output logic                                sel
);

    logic [olte_pkg::WORD_BITS-1:0] entry_reg;
    logic [olte_pkg::WORD_BITS-1:0] entry_next;
    logic [olte_pkg::CNT_W-1:0]     idx_ext;
    logic [olte_pkg::CNT_W-1:0]     idx_inc;
    logic                           in_use;

    assign idx_ext = {{(olte_pkg::CNT_W - olte_pkg::IDX_W){1'b0}}, idx};
    assign idx_inc = idx_ext + olte_pkg::CNT_W'(1);
    assign in_use  = idx_ext < ctl.cnt;

    // compare the held entry and flag the addressed slot
    assign match = in_use && (entry_reg == ctl.key);
    assign sel   = (idx == ctl.pos);
    assign entry = entry_reg;

    // pick the next entry from own value, neighbors, the write data or zero
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            olte_pkg::C_WRITE:
            begin
                if (idx == ctl.pos)
                    entry_next = ctl.wdata;
            end
            olte_pkg::C_INSERT:
            begin
                if (idx == ctl.pos)
                    entry_next = ctl.wdata;
                else if (idx > ctl.pos && idx_ext <= ctl.cnt)
                    entry_next = left_word;
            end
            olte_pkg::C_REMOVE:
            begin
                if (idx >= ctl.pos && idx_inc < ctl.cnt)
                    entry_next = right_word;
                else if (idx >= ctl.pos && idx_inc == ctl.cnt)
                    entry_next = '0;
            end
            olte_pkg::C_CLEAR:
            begin
                entry_next = '0;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

endmodule

FILE: rtl/olte_locate.sv
module olte_locate (
    input  logic                                                   clk,
    input  logic [olte_pkg::CAPACITY-1:0]                          hit_vec,
    input  logic [olte_pkg::CAPACITY-1:0]                          sel_vec,
    input  logic [olte_pkg::CAPACITY-1:0][olte_pkg::WORD_BITS-1:0] word_vec,
    output logic                                                   hit,
    output logic [olte_pkg::IDX_W-1:0]                             hit_idx,
    output logic [olte_pkg::WORD_BITS-1:0]                         rd_word
);

    logic [olte_pkg::NGRP-1:0]                          any_reg;
    logic [olte_pkg::NGRP-1:0]                          any_next;
    logic [olte_pkg::NGRP-1:0][olte_pkg::GRP_W-1:0]     loc_reg;
    logic [olte_pkg::NGRP-1:0][olte_pkg::GRP_W-1:0]     loc_next;
    logic [olte_pkg::NGRP-1:0][olte_pkg::WORD_BITS-1:0] rdg_reg;
    logic [olte_pkg::NGRP-1:0][olte_pkg::WORD_BITS-1:0] rdg_next;
    logic                                               hit_reg;
    logic                                               hit_next;
    logic [olte_pkg::IDX_W-1:0]                         idx_reg;
    logic [olte_pkg::IDX_W-1:0]                         idx_next;
    logic [olte_pkg::WORD_BITS-1:0]                     rd_reg;
    logic [olte_pkg::WORD_BITS-1:0]                     rd_next;

    // first level: first hit and selected word within each group
    always_comb
    begin
        for (int g = 0; g < olte_pkg::NGRP; g++)
        begin
            any_next[g] = 1'b0;
            loc_next[g] = '0;
            rdg_next[g] = '0;
            for (int j = olte_pkg::GRP - 1; j >= 0; j--)
            begin
                if (hit_vec[g * olte_pkg::GRP + j])
                begin
                    any_next[g] = 1'b1;
                    loc_next[g] = olte_pkg::GRP_W'(j);
                end
                if (sel_vec[g * olte_pkg::GRP + j])
                    rdg_next[g] = rdg_next[g] | word_vec[g * olte_pkg::GRP + j];
            end
        end
    end

    // second level: first group with a hit, and the selected word
    always_comb
    begin
        hit_next = 1'b0;
        idx_next = '0;
        rd_next  = '0;
        for (int g = olte_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (any_reg[g])
            begin
                hit_next = 1'b1;
                idx_next = {olte_pkg::GIDX_W'(g), loc_reg[g]};
            end
            rd_next = rd_next | rdg_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        any_reg <= any_next;
        loc_reg <= loc_next;
        rdg_reg <= rdg_next;
        hit_reg <= hit_next;
        idx_reg <= idx_next;
        rd_reg  <= rd_next;
    end

    assign hit     = hit_reg;
    assign hit_idx = idx_reg;
    assign rd_word = rd_reg;

endmodule

FILE: rtl/ordered_list_table_engine_core.sv
// Ordered list of up to CAPACITY data words held in a row of cells.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; func, position and word are sampled at that edge.
// Result channel: done is high for exactly one cycle with read_word,
// found_at, length and status valid in that cycle; the receiver cannot
// stall, so the result is lost if not taken in that cycle.
// done rises once the MATCH, FIND and EXEC states that follow the accepting
// edge have passed; busy stays high through them, so no new command is taken.
// These states go to comparing all cells, a two-level registered priority
// tree over the match flags and read selects, and the EXEC state in which every
// cell shifts, writes or clears in parallel.
// Reset: asynchronous, active low; the list empties, all entries read zero,
// and the block is idle and ready right after reset is released.
module ordered_list_table_engine_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [3:0]           func,
    input  logic [5:0]           position,
    input  logic [31:0]          word,
    output logic                 done,
    output logic [31:0]          read_word,
    output logic signed [6:0]    found_at,
    output logic [6:0]           length,
    output logic [1:0]           status
);

    localparam int CAP = olte_pkg::CAPACITY;
    localparam int WB  = olte_pkg::WORD_BITS;

    olte_pkg::state_t state_reg;
    olte_pkg::state_t state_next;

    logic [3:0]                      func_reg;
    logic [olte_pkg::IDX_W-1:0]      pos_reg;
    logic [WB-1:0]                   word_reg;
    logic [olte_pkg::CNT_W-1:0]      count_reg;
    logic [olte_pkg::CNT_W-1:0]      count_next;

    logic                            done_reg;
    logic [WB-1:0]                   rd_reg;
    logic [WB-1:0]                   rd_next;
    logic [olte_pkg::FOUND_W-1:0]    found_reg;
    logic [olte_pkg::FOUND_W-1:0]    found_next;
    olte_pkg::status_t               status_reg;
    olte_pkg::status_t               status_next;

    logic                            accept;
    logic                            in_exec;
    olte_pkg::cell_op_t              op_next;
    logic [olte_pkg::IDX_W-1:0]      tgt_pos;
    olte_pkg::cell_ctl_t             ctl;

    logic [CAP-1:0]                  hit_vec;
    logic [CAP-1:0]                  sel_vec;
    logic [CAP-1:0][WB-1:0]          word_vec;
    logic                            hit;
    logic [olte_pkg::IDX_W-1:0]      hit_idx;
    logic [WB-1:0]                   loc_word;

    logic [olte_pkg::CNT_W-1:0]      pos_ext;
    logic                            full;
    logic                            pos_oob;

    assign accept = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            olte_pkg::S_IDLE:  if (start) state_next = olte_pkg::S_MATCH;
            olte_pkg::S_MATCH: state_next = olte_pkg::S_FIND;
            olte_pkg::S_FIND:  state_next = olte_pkg::S_EXEC;
            olte_pkg::S_EXEC:  state_next = olte_pkg::S_IDLE;
            default:           state_next = olte_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy    = 1'b1;
        in_exec = 1'b0;
        unique case (state_reg)
            olte_pkg::S_IDLE:  busy = 1'b0;
            olte_pkg::S_MATCH: busy = 1'b1;
            olte_pkg::S_FIND:  busy = 1'b1;
            olte_pkg::S_EXEC:  in_exec = 1'b1;
            default:           busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= olte_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // hold the command for the whole transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            pos_reg  <= position;
            word_reg <= word[WB-1:0];
        end
    end

    assign pos_ext = {{(olte_pkg::CNT_W - olte_pkg::IDX_W){1'b0}}, pos_reg};
    assign full    = count_reg >= olte_pkg::CNT_W'(CAP);
    assign pos_oob = pos_ext >= count_reg;

    // decide the cell operation and the result
    always_comb
    begin
        op_next     = olte_pkg::C_HOLD;
        tgt_pos     = pos_reg;
        count_next  = count_reg;
        rd_next     = '0;
        found_next  = olte_pkg::NONE_IDX;
        status_next = olte_pkg::ST_OK;
        case (func_reg)
            olte_pkg::F_APPEND:
            begin
                if (full)
                    status_next = olte_pkg::ST_FULL;
                else
                begin
                    op_next    = olte_pkg::C_INSERT;
                    tgt_pos    = count_reg[olte_pkg::IDX_W-1:0];
                    count_next = count_reg + olte_pkg::CNT_W'(1);
                end
            end
            olte_pkg::F_INSERT:
            begin
                if (full)
                    status_next = olte_pkg::ST_FULL;
                else if (pos_ext > count_reg)
                    status_next = olte_pkg::ST_RANGE;
                else
                begin
                    op_next    = olte_pkg::C_INSERT;
                    count_next = count_reg + olte_pkg::CNT_W'(1);
                end
            end
            olte_pkg::F_GET:
            begin
                if (pos_oob)
                    status_next = olte_pkg::ST_RANGE;
                else
                    rd_next = loc_word;
            end
            olte_pkg::F_SET:
            begin
                if (pos_oob)
                    status_next = olte_pkg::ST_RANGE;
                else
                    op_next = olte_pkg::C_WRITE;
            end
            olte_pkg::F_REMOVE:
            begin
                if (pos_oob)
                    status_next = olte_pkg::ST_RANGE;
                else
                begin
                    op_next    = olte_pkg::C_REMOVE;
                    count_next = count_reg - olte_pkg::CNT_W'(1);
                end
            end
            olte_pkg::F_RMVAL:
            begin
                if (word_reg == '0)
                begin
                    if (pos_oob)
                        status_next = olte_pkg::ST_RANGE;
                    else
                    begin
                        op_next    = olte_pkg::C_REMOVE;
                        found_next = olte_pkg::FOUND_W'(pos_reg);
                        count_next = count_reg - olte_pkg::CNT_W'(1);
                    end
                end
                else if (hit)
                begin
                    op_next    = olte_pkg::C_REMOVE;
                    tgt_pos    = hit_idx;
                    found_next = olte_pkg::FOUND_W'(hit_idx);
                    count_next = count_reg - olte_pkg::CNT_W'(1);
                end
                else
                    status_next = olte_pkg::ST_NOTFOUND;
            end
            olte_pkg::F_SEARCH:
            begin
                if (hit)
                    found_next = olte_pkg::FOUND_W'(hit_idx);
                else
                    status_next = olte_pkg::ST_NOTFOUND;
            end
            olte_pkg::F_CLEAR:
            begin
                op_next    = olte_pkg::C_CLEAR;
                count_next = '0;
            end
            default:
            begin
                op_next = olte_pkg::C_HOLD;
            end
        endcase
    end

    // broadcast control to the cells; act only in the execute cycle
    always_comb
    begin
        ctl.op    = in_exec ? op_next : olte_pkg::C_HOLD;
        ctl.pos   = in_exec ? tgt_pos : pos_reg;
        ctl.cnt   = count_reg;
        ctl.wdata = word_reg;
        ctl.key   = word_reg;
    end

    // row of cells, each linked to its neighbors
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic [WB-1:0] left_w;
        logic [WB-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = word_vec[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = word_vec[i+1];
        end

        olte_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (olte_pkg::IDX_W'(i)),
            .ctl        (ctl),
            .left_word  (left_w),
            .right_word (right_w),
            .entry      (word_vec[i]),
            .match      (hit_vec[i]),
            .sel        (sel_vec[i])
        );
    end

    olte_locate u_locate (
        .clk      (clk),
        .hit_vec  (hit_vec),
        .sel_vec  (sel_vec),
        .word_vec (word_vec),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .rd_word  (loc_word)
    );

    // advance the count and the done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= in_exec;
            if (in_exec)
                count_reg <= count_next;
        end
    end

    // hold the result fields
    always_ff @(posedge clk)
    begin
        if (in_exec)
        begin
            rd_reg     <= rd_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign done      = done_reg;
    assign read_word = rd_reg;
    assign found_at  = found_reg;
    assign length    = count_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= olte_pkg::CNT_W'(CAP))
        else $error("entry count above capacity");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_exec |=> done)
        else $error("execute cycle not followed by result strobe");

    a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == olte_pkg::S_MATCH))
        else $error("accepted command did not start matching");

    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_exec && status_next != olte_pkg::ST_OK) |=> $stable(count_reg))
        else $error("failed command changed the count");
`endif

endmodule

FILE: tb/sv/ordered_list_table_engine_core_tb.sv
`timescale 1ns / 1ps

module ordered_list_table_engine_core_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [31:0] read_word;
        logic [6:0]  found_at;
        logic [6:0]  length;
        logic [1:0]  status;
    } list_reply_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic [3:0]        func     = '0;
    logic [5:0]        position = '0;
    logic [31:0]       word     = '0;
    logic              busy;
    logic              done;
    logic [31:0]       read_word;
    logic signed [6:0] found_at;
    logic [6:0]        length;
    logic [1:0]        status;

    // Shadow copy of the list contents and count
    logic [olte_pkg::WORD_BITS-1:0] list_words [olte_pkg::CAPACITY];
    int                             list_count;

    list_reply_t pending_replies [$];
    int          mismatch_count = 0;
    int          stall_cycles   = 0;
    bit          growing        = 1'b1;

    ordered_list_table_engine_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .position  (position),
        .word      (word),
        .done      (done),
        .read_word (read_word),
        .found_at  (found_at),
        .length    (length),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Empty the shadow list
    function automatic void clear_list();
        for (int i = 0; i < olte_pkg::CAPACITY; i++)
            list_words[i] = '0;
        list_count = 0;
    endfunction

    // Drop one entry, shift later ones down and zero the vacated slot
    function automatic void drop_entry(int at);
        for (int i = at; i + 1 < list_count; i++)
            list_words[i] = list_words[i + 1];
        list_words[list_count - 1] = '0;
        list_count--;
    endfunction

    // Return the first index in use that holds w, or -1
    function automatic int find_entry(logic [olte_pkg::WORD_BITS-1:0] w);
        for (int i = 0; i < list_count; i++)
            if (list_words[i] == w)
                return i;
        return -1;
    endfunction

    // Apply one command to the shadow list and build the reply it must give
    function automatic list_reply_t apply_command(logic [3:0] cmd, logic [5:0] pos,
                                                  logic [31:0] w);
        list_reply_t r;
        int          at;
        r.read_word = '0;
        r.found_at  = olte_pkg::NONE_IDX;
        r.status    = olte_pkg::ST_OK;
        case (cmd)
            olte_pkg::F_APPEND:
                if (list_count >= olte_pkg::CAPACITY)
                    r.status = olte_pkg::ST_FULL;
                else
                begin
                    list_words[list_count] = w;
                    list_count++;
                end
            olte_pkg::F_INSERT:
                if (list_count >= olte_pkg::CAPACITY)
                    r.status = olte_pkg::ST_FULL;
                else if (int'(pos) > list_count)
                    r.status = olte_pkg::ST_RANGE;
                else
                begin
                    for (int i = list_count; i > int'(pos); i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = w;
                    list_count++;
                end
            olte_pkg::F_GET:
                if (int'(pos) >= list_count)
                    r.status = olte_pkg::ST_RANGE;
                else
                    r.read_word = list_words[pos];
            olte_pkg::F_SET:
                if (int'(pos) >= list_count)
                    r.status = olte_pkg::ST_RANGE;
                else
                    list_words[pos] = w;
            olte_pkg::F_REMOVE:
                if (int'(pos) >= list_count)
                    r.status = olte_pkg::ST_RANGE;
                else
                    drop_entry(int'(pos));
            olte_pkg::F_RMVAL:
                if (w == '0)
                begin
                    // zero word removes by position
                    if (int'(pos) >= list_count)
                        r.status = olte_pkg::ST_RANGE;
                    else
                    begin
                        r.found_at = {1'b0, pos};
                        drop_entry(int'(pos));
                    end
                end
                else
                begin
                    at = find_entry(w);
                    if (at < 0)
                        r.status = olte_pkg::ST_NOTFOUND;
                    else
                    begin
                        r.found_at = 7'(at);
                        drop_entry(at);
                    end
                end
            olte_pkg::F_SEARCH:
            begin
                at = find_entry(w);
                if (at < 0)
                    r.status = olte_pkg::ST_NOTFOUND;
                else
                    r.found_at = 7'(at);
            end
            olte_pkg::F_CLEAR:
                clear_list();
            default:
                ;
        endcase
        r.length = 7'(list_count);
        return r;
    endfunction

    // Pick a command, leaning toward growth or shrinkage of the list
    function automatic logic [3:0] pick_command(bit grow);
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return 4'($urandom_range(9, 15));
        if (r < 3)
            return grow ? olte_pkg::F_APPEND : olte_pkg::F_CLEAR;
        if (r < 6)
            return olte_pkg::F_LENGTH;
        if (r < 14)
            return olte_pkg::F_GET;
        if (r < 20)
            return olte_pkg::F_SET;
        if (r < 30)
            return olte_pkg::F_SEARCH;
        if (grow)
        begin
            if (r < 65)
                return olte_pkg::F_APPEND;
            if (r < 90)
                return olte_pkg::F_INSERT;
            if (r < 95)
                return olte_pkg::F_REMOVE;
            return olte_pkg::F_RMVAL;
        end
        if (r < 35)
            return olte_pkg::F_APPEND;
        if (r < 40)
            return olte_pkg::F_INSERT;
        if (r < 70)
            return olte_pkg::F_REMOVE;
        return olte_pkg::F_RMVAL;
    endfunction

    // Mostly positions in range, sometimes anywhere
    function automatic logic [5:0] pick_position(logic [3:0] cmd);
        int top;
        if ($urandom_range(99) < 12)
            return 6'($urandom_range(63));
        top = (cmd == olte_pkg::F_INSERT) ? list_count : list_count - 1;
        if (top < 0)
            top = 0;
        if (top > 63)
            top = 63;
        return 6'($urandom_range(top));
    endfunction

    // Mix stored words, a small pool with duplicates, extremes and full range
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 30 && list_count > 0)
            return list_words[$urandom_range(list_count - 1)];
        if (r < 55)
            return 32'($urandom_range(1, 6));
        if (r < 60)
            return '0;
        if (r < 63)
            return '1;
        return $urandom();
    endfunction

    // Send one transaction; hold start high until the block takes it
    task automatic send_command(input logic [3:0] cmd, input logic [5:0] pos,
                                input logic [31:0] w, input int idle_pct);
        if (idle_pct > 0)
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start    <= 1'b1;
        func     <= cmd;
        position <= pos;
        word     <= w;
        do
            @(posedge clk);
        while (busy);
        pending_replies.push_back(apply_command(cmd, pos, w));
    endtask

    // Drop start and wait until every reply is in, then let the block settle
    task automatic wait_for_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // Compare each result with the oldest expected reply
    always @(posedge clk)
    begin : reply_check
        list_reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no command outstanding", $realtime);
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("read_word", want.read_word, read_word);
                check_field("found_at", {25'b0, want.found_at}, {25'b0, $unsigned(found_at)});
                check_field("length", {25'b0, want.length}, {25'b0, length});
                check_field("status", {30'b0, want.status}, {30'b0, status});
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Every command but append and clear on an empty list, and one unused code
    task automatic test_empty_list();
        send_command(olte_pkg::F_GET, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_SET, 6'd0, 32'h1234_5678, 0);
        send_command(olte_pkg::F_REMOVE, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_RMVAL, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_RMVAL, 6'd0, 32'h5, 0);
        send_command(olte_pkg::F_SEARCH, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_INSERT, 6'd1, 32'h7, 0);
        send_command(olte_pkg::F_LENGTH, 6'd0, 32'h0, 0);
        send_command(4'hF, 6'h3F, 32'hFFFF_FFFF, 0);
        wait_for_replies();
    endtask

    // Append, insert at both ends, read, overwrite, search, remove and clear
    task automatic test_edit_and_search();
        send_command(olte_pkg::F_APPEND, 6'd0, 32'hFFFF_FFFF, 0);
        send_command(olte_pkg::F_APPEND, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_INSERT, 6'd0, 32'h1, 0);
        send_command(olte_pkg::F_INSERT, 6'd3, 32'h2, 0);
        send_command(olte_pkg::F_INSERT, 6'd5, 32'h3, 0);
        send_command(olte_pkg::F_GET, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_GET, 6'd3, 32'h0, 0);
        send_command(olte_pkg::F_GET, 6'd63, 32'h0, 0);
        send_command(olte_pkg::F_SET, 6'd1, 32'hA5A5_A5A5, 0);
        send_command(olte_pkg::F_SEARCH, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_RMVAL, 6'd1, 32'h0, 0);
        send_command(olte_pkg::F_RMVAL, 6'd0, 32'h2, 0);
        send_command(olte_pkg::F_REMOVE, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_GET, 6'd1, 32'h0, 0);
        send_command(olte_pkg::F_SEARCH, 6'd0, 32'h1, 0);
        send_command(4'h9, 6'h2A, 32'h5A5A_5A5A, 0);
        send_command(olte_pkg::F_CLEAR, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_LENGTH, 6'd0, 32'h0, 0);
        send_command(olte_pkg::F_SEARCH, 6'd0, 32'h0, 0);
        wait_for_replies();
    endtask

    // Fill the list, hit the full checks, work at the top slot, then clear
    task automatic test_capacity();
        send_command(olte_pkg::F_CLEAR, 6'd0, 32'h0, 0);
        for (int i = 0; i < olte_pkg::CAPACITY; i++)
            send_command(olte_pkg::F_APPEND, 6'd0, $urandom(), 0);
        send_command(olte_pkg::F_APPEND, 6'd0, 32'h1, 0);
        send_command(olte_pkg::F_INSERT, 6'd0, 32'h1, 0);
        send_command(olte_pkg::F_INSERT, 6'd63, 32'h1, 0);
        send_command(olte_pkg::F_GET, 6'd63, 32'h0, 0);
        send_command(olte_pkg::F_SET, 6'd63, 32'hDEAD_BEEF, 0);
        send_command(olte_pkg::F_SEARCH, 6'd0, list_words[olte_pkg::CAPACITY - 1], 0);
        send_command(olte_pkg::F_REMOVE, 6'd63, 32'h0, 0);
        send_command(olte_pkg::F_INSERT, 6'd63, 32'h0BAD_CAFE, 0);
        send_command(olte_pkg::F_RMVAL, 6'd63, 32'h0, 0);
        send_command(olte_pkg::F_RMVAL, 6'd0, list_words[0], 0);
        send_command(olte_pkg::F_GET, 6'd63, 32'h0, 0);
        send_command(olte_pkg::F_CLEAR, 6'd0, 32'h0, 0);
        wait_for_replies();
    endtask

    // Random command streams that swing the list between empty and full
    task automatic test_random_traffic(input int items, input int idle_pct);
        logic [3:0]  cmd;
        logic [5:0]  pos;
        logic [31:0] w;
        for (int n = 0; n < items; n++)
        begin
            // flip the bias at the ends of the list
            if (list_count == olte_pkg::CAPACITY && $urandom_range(7) == 0)
                growing = 1'b0;
            else if (list_count <= 1 && $urandom_range(3) == 0)
                growing = 1'b1;
            cmd = pick_command(growing);
            pos = pick_position(cmd);
            w   = pick_word();
            if (cmd == olte_pkg::F_RMVAL && $urandom_range(4) == 0)
                w = '0;
            send_command(cmd, pos, w, idle_pct);
            // hold off now and then until the block is empty
            if ($urandom_range(99) == 0)
                wait_for_replies();
        end
        wait_for_replies();
    endtask

    initial
    begin
        clear_list();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_edit_and_search();
        test_capacity();
        test_random_traffic(450, 0);
        test_random_traffic(400, 81);
        test_random_traffic(350, 17);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
